FILE: hw/rtl/ccdf_pkg.sv
// Shared constants and types for the chunked container deframer.
package ccdf_pkg;

    localparam int MAX_CHUNKS  = 256;
    localparam int CHUNK_IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CHUNK_CNT_W = $clog2(MAX_CHUNKS + 1);

    localparam logic [31:0] MAGIC_WORD  = 32'h4554_4C42;
    localparam logic [7:0]  FLAGS_VALUE = 8'h0F;
    localparam logic [7:0]  MODE_RAW    = 8'h4E;
    localparam logic [7:0]  MODE_PACKED = 8'h5A;

    localparam logic [4:0] FIELD_LAST = 5'd3;
    localparam logic [4:0] ENTRY_LAST = 5'd23;

    typedef enum logic [2:0] {
        PH_MAGIC   = 3'd0,
        PH_HDRLEN  = 3'd1,
        PH_FLAGS   = 3'd2,
        PH_TABLE   = 3'd3,
        PH_MODE    = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_DONE    = 3'd6,
        PH_ERROR   = 3'd7
    } t_phase;

    typedef enum logic [2:0] {
        ST_DATA      = 3'd0,
        ST_BAD_MAGIC = 3'd1,
        ST_BAD_FLAGS = 3'd2,
        ST_BAD_MODE  = 3'd3,
        ST_TOO_MANY  = 3'd4,
        ST_EMPTY     = 3'd5
    } t_status;

endpackage

FILE: hw/rtl/chunked_container_deframer_unit.sv
// Chunked container deframer: strips container framing and streams chunk payload bytes.
//
// Input channel (i_s_*): one container byte per transaction in i_s_tdata.
// Output channel (o_m_*): one transaction per payload byte or per error.
//   tdata holds the payload byte and the low 8 bits of the chunk index,
//   tuser holds the payload kind (raw or compressed) and the status code,
//   tlast marks the final payload byte of each chunk.
// Header, table and mode bytes produce no output transaction. An error produces
// a single transaction with a non-zero status; after it, all input is consumed
// and dropped until reset. Bytes after the last chunk are dropped as well.
// Throughput is one byte per cycle in every phase unless the output stalls. A payload
// byte appears on the output in the cycle after it is accepted. The chunk size
// table lives in a synchronous single-port-write memory; its read port continuously
// fetches the entry of the current chunk, so the size is ready when the mode byte arrives.
// Reset (i_rst_n low, synchronous) returns to the magic word phase and empties
// the output register. When the receiver stalls, the output register holds its
// transaction and the input is back-pressured only while that register is full.
module chunked_container_deframer_unit
    import ccdf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] stream_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] payload_byte, [15:8] chunk_number
    output logic        o_m_tlast,   // chunk_end
    output logic [3:0]  o_m_tuser    // [0] payload_kind, [3:1] status
);

    t_phase                 r_phase, n_phase;
    logic [4:0]             r_cnt, n_cnt;
    logic [31:0]            r_asm, n_asm;
    logic [CHUNK_CNT_W-1:0] r_total, n_total;
    logic [CHUNK_CNT_W-1:0] r_tidx, n_tidx;
    logic [CHUNK_CNT_W-1:0] r_cur, n_cur;
    logic [31:0]            r_left, n_left;
    logic                   r_mode, n_mode;
    logic [31:0]            r_rd_data;

    logic [31:0] r_size_mem [MAX_CHUNKS];

    logic                   r_m_valid;
    logic [7:0]             r_m_byte;
    logic [7:0]             r_m_chunk;
    logic                   r_m_kind;
    logic                   r_m_last;
    t_status                r_m_status;

    logic                   w_accept;
    logic [31:0]            w_shift_word;
    logic [31:0]            w_magic_word;
    logic                   w_field_done;
    logic                   w_entry_done;
    logic                   w_size_field;
    logic                   w_magic_bad;
    logic                   w_flags_bad;
    logic                   w_too_many;
    logic                   w_size_small;
    logic                   w_mode_raw;
    logic                   w_mode_packed;
    logic                   w_pay_last;
    logic                   w_table_done;
    logic                   w_chunks_done;
    logic [CHUNK_CNT_W-1:0] w_tidx_inc;
    logic [CHUNK_CNT_W-1:0] w_cur_inc;
    logic [CHUNK_CNT_W+7:0] w_cur_ext;

    logic                   w_emit;
    logic                   w_mem_we;
    logic [7:0]             w_res_byte;
    logic                   w_res_kind;
    logic                   w_res_last;
    t_status                w_res_status;

    assign o_s_tready = !r_m_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_shift_word  = {r_asm[23:0], i_s_tdata};
    assign w_magic_word  = r_asm | ({24'd0, i_s_tdata} << {r_cnt[1:0], 3'b000});
    assign w_field_done  = (r_cnt == FIELD_LAST);
    assign w_entry_done  = (r_cnt == ENTRY_LAST);
    assign w_size_field  = (r_cnt <= FIELD_LAST);
    assign w_magic_bad   = (w_magic_word != MAGIC_WORD);
    assign w_flags_bad   = (w_shift_word[31:24] != FLAGS_VALUE) || (w_shift_word[23:0] == 24'd0);
    assign w_too_many    = (w_shift_word[23:0] > 24'(MAX_CHUNKS));
    assign w_size_small  = (w_shift_word < 32'd2);
    assign w_mode_raw    = (i_s_tdata == MODE_RAW);
    assign w_mode_packed = (i_s_tdata == MODE_PACKED);
    assign w_pay_last    = (r_left <= 32'd1);
    assign w_tidx_inc    = r_tidx + CHUNK_CNT_W'(1);
    assign w_cur_inc     = r_cur + CHUNK_CNT_W'(1);
    assign w_table_done  = (w_tidx_inc >= r_total);
    assign w_chunks_done = (w_cur_inc >= r_total);
    assign w_cur_ext     = {8'd0, r_cur};

    // Phase sequencing.
    always_comb begin
        n_phase = r_phase;
        if (w_accept) begin
            case (r_phase)
                PH_MAGIC: begin
                    if (w_field_done) begin
                        n_phase = w_magic_bad ? PH_ERROR : PH_HDRLEN;
                    end
                end
                PH_HDRLEN: begin
                    if (w_field_done) begin
                        n_phase = PH_FLAGS;
                    end
                end
                PH_FLAGS: begin
                    if (w_field_done) begin
                        n_phase = (w_flags_bad || w_too_many) ? PH_ERROR : PH_TABLE;
                    end
                end
                PH_TABLE: begin
                    if (w_field_done && w_size_small) begin
                        n_phase = PH_ERROR;
                    end else if (w_entry_done && w_table_done) begin
                        n_phase = PH_MODE;
                    end
                end
                PH_MODE: begin
                    n_phase = (w_mode_raw || w_mode_packed) ? PH_PAYLOAD : PH_ERROR;
                end
                PH_PAYLOAD: begin
                    if (w_pay_last) begin
                        n_phase = w_chunks_done ? PH_DONE : PH_MODE;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // Field assembly, table bookkeeping and result generation.
    always_comb begin
        n_cnt        = r_cnt;
        n_asm        = r_asm;
        n_total      = r_total;
        n_tidx       = r_tidx;
        n_cur        = r_cur;
        n_left       = r_left;
        n_mode       = r_mode;
        w_emit       = 1'b0;
        w_mem_we     = 1'b0;
        w_res_byte   = 8'd0;
        w_res_kind   = 1'b0;
        w_res_last   = 1'b0;
        w_res_status = ST_DATA;
        if (w_accept) begin
            case (r_phase)
                PH_MAGIC: begin
                    n_asm = w_magic_word;
                    if (w_field_done) begin
                        n_cnt = 5'd0;
                        if (w_magic_bad) begin
                            w_emit       = 1'b1;
                            w_res_status = ST_BAD_MAGIC;
                        end else begin
                            n_asm = 32'd0;
                        end
                    end else begin
                        n_cnt = r_cnt + 5'd1;
                    end
                end
                PH_HDRLEN: begin
                    n_cnt = w_field_done ? 5'd0 : r_cnt + 5'd1;
                end
                PH_FLAGS: begin
                    n_asm = w_shift_word;
                    if (w_field_done) begin
                        n_cnt = 5'd0;
                        if (w_flags_bad) begin
                            w_emit       = 1'b1;
                            w_res_status = ST_BAD_FLAGS;
                        end else if (w_too_many) begin
                            w_emit       = 1'b1;
                            w_res_status = ST_TOO_MANY;
                        end else begin
                            n_total = CHUNK_CNT_W'(w_shift_word[23:0]);
                            n_tidx  = '0;
                            n_asm   = 32'd0;
                        end
                    end else begin
                        n_cnt = r_cnt + 5'd1;
                    end
                end
                PH_TABLE: begin
                    if (w_size_field) begin
                        n_asm = w_shift_word;
                    end
                    if (w_field_done && w_size_small) begin
                        w_emit       = 1'b1;
                        w_res_status = ST_EMPTY;
                    end else begin
                        if (w_field_done) begin
                            w_mem_we = 1'b1;
                            n_asm    = 32'd0;
                        end
                        if (w_entry_done) begin
                            n_cnt  = 5'd0;
                            n_tidx = w_tidx_inc;
                            if (w_table_done) begin
                                n_cur = '0;
                            end
                        end else begin
                            n_cnt = r_cnt + 5'd1;
                        end
                    end
                end
                PH_MODE: begin
                    if (w_mode_raw || w_mode_packed) begin
                        n_mode = w_mode_packed;
                        n_left = r_rd_data - 32'd1;
                    end else begin
                        w_emit       = 1'b1;
                        w_res_status = ST_BAD_MODE;
                    end
                end
                PH_PAYLOAD: begin
                    w_emit     = 1'b1;
                    w_res_byte = i_s_tdata;
                    w_res_kind = r_mode;
                    w_res_last = w_pay_last;
                    if (w_pay_last) begin
                        n_left = 32'd0;
                        n_cur  = w_cur_inc;
                    end else begin
                        n_left = r_left - 32'd1;
                    end
                end
                default: begin
                    w_emit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC;
            r_cnt   <= 5'd0;
            r_asm   <= 32'd0;
            r_total <= '0;
            r_tidx  <= '0;
            r_cur   <= '0;
            r_left  <= 32'd0;
            r_mode  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_asm   <= n_asm;
            r_total <= n_total;
            r_tidx  <= n_tidx;
            r_cur   <= n_cur;
            r_left  <= n_left;
            r_mode  <= n_mode;
        end
    end

    // The read port always tracks the next value of the current chunk index, so the size of the
    // chunk in progress is waiting in r_rd_data when its mode byte arrives.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_size_mem[r_tidx[CHUNK_IDX_W-1:0]] <= w_shift_word;
        end
        r_rd_data <= r_size_mem[n_cur[CHUNK_IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_accept) begin
            r_m_valid <= w_emit;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_emit) begin
            r_m_byte   <= w_res_byte;
            r_m_chunk  <= w_cur_ext[7:0];
            r_m_kind   <= w_res_kind;
            r_m_last   <= w_res_last;
            r_m_status <= w_res_status;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {r_m_chunk, r_m_byte};
    assign o_m_tlast  = r_m_last;
    assign o_m_tuser  = {r_m_status, r_m_kind};

endmodule
